/* rtl/rbsi_pkg.sv */
// Shared types and constants for the ray versus box slab intersection block.
// No dependencies; imported by every module of the block.
package rbsi_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int FRAC_W  = 16;
	localparam int DIST_W  = 47;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  tdist_t;

	// one request: box corners, ray origin, reciprocal direction
	typedef struct packed {
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t inv_dir_x;
		coord_t inv_dir_y;
		coord_t inv_dir_z;
	} ray_t;

	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] distance;
	} result_t;

endpackage

/* rtl/rbsi_slab.sv */
// One axis of the slab test: picks near/far planes by the reciprocal's sign
// and forms exact Q.32 entry and exit distances. Depends on rbsi_pkg.
module rbsi_slab import rbsi_pkg::*; (
	input  coord_t lo,
	input  coord_t hi,
	input  coord_t org,
	input  coord_t inv,
	output tdist_t t_near,
	output tdist_t t_far
);

	logic                     neg;
	coord_t                   near_p;
	coord_t                   far_p;
	logic signed [DIFF_W-1:0] near_d;
	logic signed [DIFF_W-1:0] far_d;
	logic signed [PROD_W:0]   near_full;
	logic signed [PROD_W:0]   far_full;

	// negative direction swaps the planes; zero counts as positive
	assign neg    = inv[COORD_W-1];
	assign near_p = neg ? hi : lo;
	assign far_p  = neg ? lo : hi;

	// plane minus origin is exact in one extra bit
	assign near_d = DIFF_W'(near_p) - DIFF_W'(org);
	assign far_d  = DIFF_W'(far_p) - DIFF_W'(org);

	// exact products; magnitude stays below 2^63 so the top bit is a copy of the sign
	assign near_full = near_d * inv;
	assign far_full  = far_d * inv;
	assign t_near    = $signed(near_full[PROD_W-1:0]);
	assign t_far     = $signed(far_full[PROD_W-1:0]);

endmodule

/* rtl/ray_box_slab_intersect_top.sv */
// Ray versus axis-aligned box test, slab method, fixed point.
// Throughput: one request per cycle while the output is not stalled; the six slab multipliers sit in their own stage.
// Stages: input register, product register, result register; a stall ripples back
// only through full stages. Reset clears the stage valid bits, payload is not reset.
module ray_box_slab_intersect_top import rbsi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    ray_valid,
	output logic    ray_stall,
	input  ray_t    ray,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic    v_s1, v_s2, v_s3;
	logic    adv1, adv2, adv3;
	ray_t    ray_s1;
	tdist_t  tx_n, tx_f, ty_n, ty_f, tz_n, tz_f;
	tdist_t  tx_n_s2, tx_f_s2, ty_n_s2, ty_f_s2, tz_n_s2, tz_f_s2;
	tdist_t  t_entry;
	logic    overlap_xy, overlap_z, sel_y, sel_z, hit_c;
	result_t res_c;
	result_t res_s3;

	// stage advance: a stage may load when it is empty or moving on
	assign adv3      = !v_s3 || !result_stall;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign ray_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= ray_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv1 && ray_valid) ray_s1 <= ray;
	end

	// per-axis distances
	rbsi_slab u_slab_x (
		.lo(ray_s1.box_min_x), .hi(ray_s1.box_max_x),
		.org(ray_s1.origin_x), .inv(ray_s1.inv_dir_x),
		.t_near(tx_n), .t_far(tx_f)
	);
	rbsi_slab u_slab_y (
		.lo(ray_s1.box_min_y), .hi(ray_s1.box_max_y),
		.org(ray_s1.origin_y), .inv(ray_s1.inv_dir_y),
		.t_near(ty_n), .t_far(ty_f)
	);
	rbsi_slab u_slab_z (
		.lo(ray_s1.box_min_z), .hi(ray_s1.box_max_z),
		.org(ray_s1.origin_z), .inv(ray_s1.inv_dir_z),
		.t_near(tz_n), .t_far(tz_f)
	);

	// product register
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			tx_n_s2 <= tx_n;
			tx_f_s2 <= tx_f;
			ty_n_s2 <= ty_n;
			ty_f_s2 <= ty_f;
			tz_n_s2 <= tz_n;
			tz_f_s2 <= tz_f;
		end
	end

	// interval merge: all compares run side by side on the stored products.
	// max(near) > far_z is the same as either near exceeding it, and likewise
	// near_z > min(far) is near_z exceeding either far.
	always_comb begin
		overlap_xy = !((tx_n_s2 > ty_f_s2) || (ty_n_s2 > tx_f_s2));
		overlap_z  = !((tx_n_s2 > tz_f_s2) || (ty_n_s2 > tz_f_s2) ||
			(tz_n_s2 > tx_f_s2) || (tz_n_s2 > ty_f_s2));
		sel_z = (tz_n_s2 > tx_n_s2) && (tz_n_s2 > ty_n_s2);
		sel_y = !sel_z && (ty_n_s2 > tx_n_s2);
		if (sel_z) begin
			t_entry = tz_n_s2;
		end else if (sel_y) begin
			t_entry = ty_n_s2;
		end else begin
			t_entry = tx_n_s2;
		end
		hit_c = overlap_xy && overlap_z && !t_entry[PROD_W-1] && (|t_entry);
		res_c.hit = hit_c;
		// a positive entry stays below 2^63, so dropping the low FRAC_W fraction bits fits the field
		res_c.distance = hit_c ? t_entry[FRAC_W +: DIST_W] : DIST_MAX;
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv3 && v_s2) res_s3 <= res_c;
	end

	assign result_valid = v_s3;
	assign result       = res_s3;

endmodule

/* rtl/rbsi_checker.sv */
// Port-level checks for the ray versus box slab intersection block, and the
// bind that attaches them to the top level. Depends on rbsi_pkg.
module rbsi_checker import rbsi_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    ray_valid,
	input logic    ray_stall,
	input ray_t    ray,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	logic       req_acc, res_acc;
	logic [2:0] pending_q;

	assign req_acc = ray_valid && !ray_stall;
	assign res_acc = result_valid && !result_stall;

	// requests in flight or waiting at the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(req_acc) - 3'(res_acc);
		end
	end

	// a result is only shown for a request that was taken
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 3'd0)
		else $error("result without outstanding request");

	// a stalled request stays offered and unchanged
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid && ray_stall |=> ray_valid && $stable(ray))
		else $error("stalled request changed");

	// with the output free, an accepted request reaches it through the input, product and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc ##1 !result_stall ##1 !result_stall |=> result_valid)
		else $error("result late");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_miss_dist: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit |-> result.distance == DIST_MAX)
		else $error("miss without largest distance");

endmodule

bind ray_box_slab_intersect_top rbsi_checker u_rbsi_checker (
	.clk(clk),
	.arst_n(arst_n),
	.ray_valid(ray_valid),
	.ray_stall(ray_stall),
	.ray(ray),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result(result)
);

/* sim/ray_box_slab_intersect_checker.sv */
// Result checker for the ray versus box slab test: predicts hit and entry distance
// for every accepted request and compares them in order. Depends on rbsi_pkg.
module ray_box_slab_intersect_checker import rbsi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    ray_valid,
	input  logic    ray_stall,
	input  ray_t    ray,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      fail_count,
	output int      open_count
);

	result_t pending_hits[$];
	int      n_fail = 0;
	int      n_open = 0;

	assign fail_count = n_fail;
	assign open_count = n_open;

	// entry and exit distance along one axis, exact Q.32
	function automatic void slab_span(input coord_t lo, input coord_t hi, input coord_t org,
			input coord_t inv, output tdist_t t_in, output tdist_t t_out);
		tdist_t near_p, far_p;
		near_p = inv[COORD_W-1] ? tdist_t'(hi) : tdist_t'(lo);
		far_p  = inv[COORD_W-1] ? tdist_t'(lo) : tdist_t'(hi);
		t_in   = (near_p - tdist_t'(org)) * tdist_t'(inv);
		t_out  = (far_p - tdist_t'(org)) * tdist_t'(inv);
	endfunction

	function automatic result_t slab_hit_of(input ray_t r);
		result_t res;
		tdist_t  t_in, t_out, y_in, y_out, z_in, z_out, q;
		res.hit      = 1'b0;
		res.distance = DIST_MAX;
		slab_span(r.box_min_x, r.box_max_x, r.origin_x, r.inv_dir_x, t_in, t_out);
		slab_span(r.box_min_y, r.box_max_y, r.origin_y, r.inv_dir_y, y_in, y_out);
		// x and y intervals must overlap, then merge
		if (!(t_in > y_out || y_in > t_out)) begin
			if (y_in > t_in)
				t_in = y_in;
			if (y_out < t_out)
				t_out = y_out;
			slab_span(r.box_min_z, r.box_max_z, r.origin_z, r.inv_dir_z, z_in, z_out);
			if (!(t_in > z_out || z_in > t_out)) begin
				if (z_in > t_in)
					t_in = z_in;
				// only an entry strictly in front of the origin counts
				if (t_in > 0) begin
					q        = t_in >>> FRAC_W;
					res.hit  = 1'b1;
					res.distance = (q > tdist_t'({1'b0, DIST_MAX})) ? DIST_MAX
						: q[DIST_W-1:0];
				end
			end
		end
		return res;
	endfunction

	// compare first, then queue the new request's prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_hits.size() == 0) begin
					$error("result with no request outstanding: hit %0b distance %0h",
						result.hit, result.distance);
					n_fail++;
				end else begin
					want = pending_hits.pop_front();
					if (result.hit !== want.hit) begin
						$error("hit mismatch: expected %0b, actual %0b", want.hit, result.hit);
						n_fail++;
					end
					if (result.distance !== want.distance) begin
						$error("distance mismatch: expected %0h, actual %0h",
							want.distance, result.distance);
						n_fail++;
					end
				end
			end
			if (ray_valid && !ray_stall)
				pending_hits.push_back(slab_hit_of(ray));
			n_open = pending_hits.size();
		end
	end

endmodule

/* sim/ray_box_slab_intersect_top_test.sv */
// Testbench top for ray_box_slab_intersect_top: drives directed and random ray/box
// requests with random idling on both sides. Depends on rbsi_pkg and the checker.
module ray_box_slab_intersect_top_test;
	import rbsi_pkg::*;

	localparam int     N_RANDOM  = 1830;
	localparam int     N_CALM    = 150;
	localparam int     CYCLE_CAP = 200000;
	localparam coord_t ONE  = 32'sh0001_0000;
	localparam coord_t MAXC = 32'sh7fff_ffff;
	localparam coord_t MINC = 32'sh8000_0000;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    ray_valid;
	logic    ray_stall;
	ray_t    ray;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	int      fail_count;
	int      open_count;
	int      n_sent = 0;
	int      cycle_count;
	bit      calm = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	ray_box_slab_intersect_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.ray_valid    (ray_valid),
		.ray_stall    (ray_stall),
		.ray          (ray),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	ray_box_slab_intersect_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.ray_valid    (ray_valid),
		.ray_stall    (ray_stall),
		.ray          (ray),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.open_count   (open_count)
	);

	function automatic ray_t mk_ray(input coord_t lx, input coord_t ly, input coord_t lz,
			input coord_t hx, input coord_t hy, input coord_t hz,
			input coord_t ox, input coord_t oy, input coord_t oz,
			input coord_t ix, input coord_t iy, input coord_t iz);
		ray_t r;
		r.box_min_x = lx; r.box_min_y = ly; r.box_min_z = lz;
		r.box_max_x = hx; r.box_max_y = hy; r.box_max_z = hz;
		r.origin_x  = ox; r.origin_y  = oy; r.origin_z  = oz;
		r.inv_dir_x = ix; r.inv_dir_y = iy; r.inv_dir_z = iz;
		return r;
	endfunction

	// mostly small values, sometimes extremes or raw 32-bit noise
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return MAXC;
					1: return MINC;
					2: return '0;
					3: return '1;
					default: return 32'sd1;
				endcase
			end
			1, 2: return coord_t'($urandom);
			default: return coord_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	// ray from a random origin through a point of the box, reached near t = 1
	function automatic ray_t aimed_ray();
		ray_t   r;
		int     lo[3], hi[3], org[3], inv[3];
		int     ext, aim, span, tmp;
		longint d;
		for (int a = 0; a < 3; a++) begin
			lo[a] = int'($urandom_range(0, 1 << 22)) - (1 << 21);
			ext   = int'($urandom_range(0, 1 << 20));
			hi[a] = lo[a] + ext;
			aim   = lo[a] + int'($urandom_range(0, ext));
			span  = int'($urandom_range(1 << 14, 1 << 22));
			case ($urandom_range(0, 7))
				0:       org[a] = aim;
				1, 2, 3: org[a] = aim - span;
				default: org[a] = aim + span;
			endcase
			d = longint'(aim) - longint'(org[a]);
			if (d == 0)
				inv[a] = ($urandom_range(0, 1) == 0) ? int'($urandom_range(1, 1 << 20))
					: -int'($urandom_range(1, 1 << 20));
			else
				inv[a] = int'((longint'(1) << 32) / d) + int'($urandom_range(0, 16)) - 8;
			// zero reciprocal and inverted box now and then
			if ($urandom_range(0, 15) == 0)
				inv[a] = 0;
			if ($urandom_range(0, 19) == 0) begin
				tmp    = lo[a];
				lo[a]  = hi[a];
				hi[a]  = tmp;
			end
		end
		r = mk_ray(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], org[0], org[1], org[2],
			inv[0], inv[1], inv[2]);
		return r;
	endfunction

	// present one request, with an optional idle burst first; returns at a falling edge
	task automatic offer(input ray_t r);
		if (!calm && (n_sent % 256) < 192 && $urandom_range(0, 3) == 0) begin
			ray_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		ray_valid <= 1'b1;
		ray       <= r;
		do
			@(posedge clk);
		while (ray_stall);
		n_sent++;
		@(negedge clk);
	endtask

	// receiver: one long hold-off to fill the pipe, then random stall bursts
	initial begin
		result_stall = 1'b0;
		wait (n_sent >= 120);
		@(negedge clk);
		result_stall <= 1'b1;
		repeat (300) @(negedge clk);
		forever begin
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_CAP) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		ray_t r;
		arst_n    = 1'b0;
		ray_valid = 1'b0;
		ray       = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: plain hits both ways, misses, edge distances, extremes
		offer(mk_ray(ONE, -ONE, -ONE, 2*ONE, ONE, ONE, 0, 0, 0, ONE, MAXC, MAXC));
		offer(mk_ray(-2*ONE, -ONE, -ONE, -ONE, ONE, ONE, 0, 0, 0, -ONE, MINC, MINC));
		offer(mk_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE));
		offer(mk_ray(ONE, -ONE, -ONE, 2*ONE, ONE, ONE, ONE, 0, 0, ONE, MAXC, MAXC));
		offer(mk_ray(32'sd1, -ONE, -ONE, 2*ONE, ONE, ONE, 0, 0, 0, 32'sd1, MAXC, MAXC));
		offer(mk_ray(ONE, ONE, -ONE, 2*ONE, 2*ONE, ONE, 0, 0, 0, ONE, ONE/4, MAXC));
		offer(mk_ray(ONE, ONE, 5*ONE, 2*ONE, 2*ONE, 6*ONE, 0, 0, 0, ONE, ONE, ONE));
		offer(mk_ray(ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 0, 0, 0, 0, 0, 0));
		offer(mk_ray(ONE, -ONE, -ONE, 2*ONE, ONE, ONE, 0, 3*ONE, 0, ONE, 0, MAXC));
		offer(mk_ray(2*ONE, ONE, ONE, ONE, -ONE, -ONE, 0, 0, 0, ONE, MAXC, MAXC));
		offer(mk_ray(2*ONE, 2*ONE, 2*ONE, ONE, ONE, ONE, 0, 0, 0, -ONE, -ONE, -ONE));
		offer(mk_ray(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC,
			MINC, MINC, MINC));
		offer(mk_ray(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
			MAXC, MAXC, MAXC));
		offer(mk_ray('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
		offer(mk_ray('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
		offer(mk_ray(MAXC - ONE, MINC, MINC, MAXC, MAXC, MAXC, MINC, 0, 0,
			MAXC, MAXC, MAXC));
		offer(mk_ray(MINC, MINC, MINC, MINC + ONE, MAXC, MAXC, MAXC, 0, 0,
			MINC, MINC, MAXC));
		offer(mk_ray(-ONE, ONE, -ONE, ONE, 3*ONE, ONE, -4*ONE, 0, 4*ONE,
			ONE/2, ONE, -ONE/2));

		// random: aimed rays, raw noise, aimed rays with one noisy field
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= N_RANDOM - N_CALM);
			case ($urandom_range(0, 9))
				7, 8: r = mk_ray(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord());
				9: begin
					r = aimed_ray();
					case ($urandom_range(0, 3))
						0: r.inv_dir_y = coord_t'($urandom);
						1: r.origin_z  = coord_t'($urandom);
						2: r.box_max_x = coord_t'($urandom);
						default: r.box_min_z = coord_t'($urandom);
					endcase
				end
				default: r = aimed_ray();
			endcase
			offer(r);
		end
		ray_valid <= 1'b0;

		wait (open_count == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
